// ----- rtl/cecc_pkg.sv -----
// Package: shared types, constants and field widths of the CIGAR edge clip classifier
`default_nettype none
package cecc_pkg;

   localparam int OP_LEN_BITS = 28;
   localparam int SPAN_BITS   = 40;
   localparam int SUM_BITS    = 32;
   localparam int POS_BITS    = 31;
   localparam int CLEN_BITS   = 32;
   localparam int TOTAL_BITS  = SPAN_BITS + 2;

   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_M    = 8'h4D;
   localparam logic [7:0] CH_I    = 8'h49;
   localparam logic [7:0] CH_D    = 8'h44;
   localparam logic [7:0] CH_S    = 8'h53;
   localparam logic [7:0] CH_H    = 8'h48;
   localparam logic [7:0] OP_NONE = 8'h00;

   localparam logic [1:0] EDGE_NONE  = 2'd0;
   localparam logic [1:0] EDGE_LEFT  = 2'd1;
   localparam logic [1:0] EDGE_RIGHT = 2'd2;
   localparam logic [1:0] EDGE_BAD   = 2'd3;

   typedef struct packed {
      logic [7:0]           cigar_char;
      logic                 is_last;
      logic [POS_BITS-1:0]  start_pos;
      logic [CLEN_BITS-1:0] contig_len;
   } req_type;

   typedef struct packed {
      logic [1:0]          edge_code;
      logic [SUM_BITS-1:0] len_with_clips;
      logic [SUM_BITS-1:0] len_with_dels;
   } rsp_type;

   typedef struct packed {
      logic                   first_clip;
      logic [OP_LEN_BITS-1:0] first_len;
      logic                   last_clip;
      logic [OP_LEN_BITS-1:0] last_len;
      logic [SPAN_BITS-1:0]   ref_span;
      logic [POS_BITS-1:0]    start_pos;
      logic [CLEN_BITS-1:0]   contig_len;
      logic [SUM_BITS-1:0]    sum_with_clips;
      logic [SUM_BITS-1:0]    sum_with_dels;
   } fin_type;

endpackage
`default_nettype wire

// ----- rtl/cecc_scan.sv -----
// Record scanner: builds operation lengths and running sums, one character per cycle while go is high
`default_nettype none
module cecc_scan (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              go,
   input  wire logic [7:0]                        ch,
   input  wire logic                              is_last,
   input  wire logic [cecc_pkg::POS_BITS-1:0]     start_pos,
   input  wire logic [cecc_pkg::CLEN_BITS-1:0]    contig_len,
   output      cecc_pkg::fin_type                 fin
);

   localparam int LB = cecc_pkg::OP_LEN_BITS;
   localparam int SB = cecc_pkg::SPAN_BITS;
   localparam int QB = cecc_pkg::SUM_BITS;

   logic [LB-1:0] digit_ff, digit_in;
   logic          have_ff, have_in;
   logic [7:0]    first_op_ff, first_op_in;
   logic [7:0]    last_op_ff, last_op_in;
   logic [LB-1:0] first_len_ff, first_len_in;
   logic [LB-1:0] last_len_ff, last_len_in;
   logic [SB-1:0] span_ff, span_in;
   logic [QB-1:0] clips_ff, clips_in;
   logic [QB-1:0] dels_ff, dels_in;

   logic [LB-1:0] nx_digit;
   logic          nx_have;
   logic [7:0]    nx_first_op, nx_last_op;
   logic [LB-1:0] nx_first_len, nx_last_len;
   logic [SB-1:0] nx_span;
   logic [QB-1:0] nx_clips, nx_dels;

   logic          is_digit;
   logic          close_op;
   logic [LB+3:0] times_ten;
   logic [SB:0]   span_sum;
   logic [QB:0]   clips_sum, dels_sum;
   logic          add_span, add_clips, add_dels;

   always_comb begin
      is_digit  = (ch >= cecc_pkg::CH_ZERO) && (ch <= cecc_pkg::CH_NINE);
      close_op  = !is_digit && have_ff;
      times_ten = {1'b0, digit_ff, 3'b000} + {3'b000, digit_ff, 1'b0}
                  + {{LB{1'b0}}, ch[3:0]};
      add_span  = (ch != cecc_pkg::CH_I) && (ch != cecc_pkg::CH_S) && (ch != cecc_pkg::CH_H);
      add_clips = (ch == cecc_pkg::CH_M) || (ch == cecc_pkg::CH_I) || (ch == cecc_pkg::CH_S);
      add_dels  = (ch == cecc_pkg::CH_M) || (ch == cecc_pkg::CH_I) || (ch == cecc_pkg::CH_D);
      span_sum  = {1'b0, span_ff} + {{(SB-LB+1){1'b0}}, digit_ff};
      clips_sum = {1'b0, clips_ff} + {{(QB-LB+1){1'b0}}, digit_ff};
      dels_sum  = {1'b0, dels_ff} + {{(QB-LB+1){1'b0}}, digit_ff};

      nx_digit     = digit_ff;
      nx_have      = have_ff;
      nx_first_op  = first_op_ff;
      nx_first_len = first_len_ff;
      nx_last_op   = last_op_ff;
      nx_last_len  = last_len_ff;
      nx_span      = span_ff;
      nx_clips     = clips_ff;
      nx_dels      = dels_ff;

      if (is_digit) begin
         nx_digit = (times_ten[LB+3:LB] != 4'd0) ? {LB{1'b1}} : times_ten[LB-1:0];
         nx_have  = 1'b1;
      end else if (close_op) begin
         nx_digit = '0;
         nx_have  = 1'b0;
         if (first_op_ff == cecc_pkg::OP_NONE) begin
            nx_first_op  = ch;
            nx_first_len = digit_ff;
         end
         nx_last_op  = ch;
         nx_last_len = digit_ff;
         if (add_span) begin
            nx_span = span_sum[SB] ? {SB{1'b1}} : span_sum[SB-1:0];
         end
         if (add_clips) begin
            nx_clips = clips_sum[QB] ? {QB{1'b1}} : clips_sum[QB-1:0];
         end
         if (add_dels) begin
            nx_dels = dels_sum[QB] ? {QB{1'b1}} : dels_sum[QB-1:0];
         end
      end

      fin.first_clip     = (nx_first_op == cecc_pkg::CH_S) || (nx_first_op == cecc_pkg::CH_H);
      fin.first_len      = nx_first_len;
      fin.last_clip      = (nx_last_op == cecc_pkg::CH_S) || (nx_last_op == cecc_pkg::CH_H);
      fin.last_len       = nx_last_len;
      fin.ref_span       = nx_span;
      fin.start_pos      = start_pos;
      fin.contig_len     = contig_len;
      fin.sum_with_clips = nx_clips;
      fin.sum_with_dels  = nx_dels;

      digit_in     = digit_ff;
      have_in      = have_ff;
      first_op_in  = first_op_ff;
      first_len_in = first_len_ff;
      last_op_in   = last_op_ff;
      last_len_in  = last_len_ff;
      span_in      = span_ff;
      clips_in     = clips_ff;
      dels_in      = dels_ff;
      if (go && is_last) begin
         digit_in     = '0;
         have_in      = 1'b0;
         first_op_in  = cecc_pkg::OP_NONE;
         first_len_in = '0;
         last_op_in   = cecc_pkg::OP_NONE;
         last_len_in  = '0;
         span_in      = '0;
         clips_in     = '0;
         dels_in      = '0;
      end else if (go) begin
         digit_in     = nx_digit;
         have_in      = nx_have;
         first_op_in  = nx_first_op;
         first_len_in = nx_first_len;
         last_op_in   = nx_last_op;
         last_len_in  = nx_last_len;
         span_in      = nx_span;
         clips_in     = nx_clips;
         dels_in      = nx_dels;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff     <= '0;
         have_ff      <= 1'b0;
         first_op_ff  <= cecc_pkg::OP_NONE;
         first_len_ff <= '0;
         last_op_ff   <= cecc_pkg::OP_NONE;
         last_len_ff  <= '0;
         span_ff      <= '0;
         clips_ff     <= '0;
         dels_ff      <= '0;
      end else begin
         digit_ff     <= digit_in;
         have_ff      <= have_in;
         first_op_ff  <= first_op_in;
         first_len_ff <= first_len_in;
         last_op_ff   <= last_op_in;
         last_len_ff  <= last_len_in;
         span_ff      <= span_in;
         clips_ff     <= clips_in;
         dels_ff      <= dels_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/cigar_edge_clip_classifier_unit.sv -----
// Top level: CIGAR edge clip classifier with input, record-end and response registers
// A request flagged last passes the input, record-end and response registers before its response is valid.
// Throughput: one request per cycle while neither the response stall nor a held record-end register holds it.
// Requests not flagged last give no response and retire in the scanner stage.
// Synchronous reset clears all pipeline valids and the record state.
`default_nettype none
module cigar_edge_clip_classifier_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire cecc_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      cecc_pkg::rsp_type rsp_data
);

   localparam int TB = cecc_pkg::TOTAL_BITS;

   logic              in_v_ff, in_v_in;
   cecc_pkg::req_type in_ff;
   logic              fin_v_ff, fin_v_in;
   cecc_pkg::fin_type fin_ff;
   cecc_pkg::fin_type fin_nx;
   logic              rsp_v_ff, rsp_v_in;
   cecc_pkg::rsp_type rsp_ff;
   cecc_pkg::rsp_type rsp_nx;

   logic              out_free, fin_go, fin_free, proc_go, in_free, req_take;
   logic              left_hit, right_hit;
   logic [TB-1:0]     end_total;

   cecc_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .go         (proc_go),
      .ch         (in_ff.cigar_char),
      .is_last    (in_ff.is_last),
      .start_pos  (in_ff.start_pos),
      .contig_len (in_ff.contig_len),
      .fin        (fin_nx)
   );

   always_comb begin
      out_free  = !rsp_v_ff || !rsp_stall;
      fin_go    = fin_v_ff && out_free;
      fin_free  = !fin_v_ff || fin_go;
      proc_go   = in_v_ff && (!in_ff.is_last || fin_free);
      in_free   = !in_v_ff || proc_go;
      req_stall = !in_free;
      req_take  = req_valid && in_free;

      in_v_in  = in_free ? req_valid : in_v_ff;
      fin_v_in = (proc_go && in_ff.is_last) || (fin_v_ff && !fin_go);
      rsp_v_in = fin_go || (rsp_v_ff && !out_free);

      left_hit  = fin_ff.first_clip &&
                  ({{(cecc_pkg::CLEN_BITS-cecc_pkg::OP_LEN_BITS){1'b0}}, fin_ff.first_len}
                   > {1'b0, fin_ff.start_pos});
      end_total = {2'b00, fin_ff.ref_span}
                  + {{(TB-cecc_pkg::POS_BITS){1'b0}}, fin_ff.start_pos}
                  + {{(TB-cecc_pkg::OP_LEN_BITS){1'b0}}, fin_ff.last_len};
      right_hit = fin_ff.last_clip &&
                  (end_total > {{(TB-cecc_pkg::CLEN_BITS){1'b0}}, fin_ff.contig_len});

      if (left_hit) begin
         rsp_nx.edge_code = cecc_pkg::EDGE_LEFT;
      end else if (right_hit) begin
         rsp_nx.edge_code = cecc_pkg::EDGE_RIGHT;
      end else begin
         rsp_nx.edge_code = cecc_pkg::EDGE_NONE;
      end
      rsp_nx.len_with_clips = fin_ff.sum_with_clips;
      rsp_nx.len_with_dels  = fin_ff.sum_with_dels;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         fin_v_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         in_v_ff  <= in_v_in;
         fin_v_ff <= fin_v_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= req_data;
      end
      if (proc_go && in_ff.is_last) begin
         fin_ff <= fin_nx;
      end
      if (fin_go) begin
         rsp_ff <= rsp_nx;
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ----- rtl/cecc_checker.sv -----
// Checker: port-level assertions on the CIGAR edge clip classifier, with its bind
`default_nettype none
module cecc_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire cecc_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire cecc_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_edge_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.edge_code != cecc_pkg::EDGE_BAD)
      else $error("illegal edge code");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   a_fresh_rsp: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !$past(reset) && !$past(req_valid, 1) && !$past(req_valid, 2)
      && !$past(req_valid, 3) && !$past(reset, 2) && !$past(reset, 3)
      && $past(!rsp_valid, 1) && $past(!rsp_valid, 2) |=> !rsp_valid)
      else $error("response without request");

endmodule

bind cigar_edge_clip_classifier_unit cecc_checker u_cecc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire
